// ===== hdl/usor_pkg.sv =====
// Package: shared types and constants of the UDP socket offload register file.
package usor_pkg;

    localparam int SocketCount = 4;
    localparam int BufferBytes = 2048;

    typedef enum logic [1:0] {
        OP_BUS_READ  = 2'd0,
        OP_BUS_WRITE = 2'd1,
        OP_RX_BYTE   = 2'd2,
        OP_TX_PULL   = 2'd3
    } t_op;

    localparam logic [7:0] CMD_OPEN  = 8'h01;
    localparam logic [7:0] CMD_CLOSE = 8'h10;
    localparam logic [7:0] CMD_SEND  = 8'h20;
    localparam logic [7:0] CMD_RECV  = 8'h40;
    localparam logic [1:0] MODE_UDP  = 2'd2;

    localparam logic [15:0] FREE_SIZE_BASE = 16'h0800;
    localparam logic [7:0]  IMR_VALUE      = 8'hef;
    localparam logic [7:0]  MSIZE_VALUE    = 8'h55;
    localparam logic [7:0]  STATUS_UDP     = 8'h22;
    localparam logic [7:0]  BAD_READ       = 8'hff;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  net_socket;
        logic [7:0]  net_byte;
        logic        net_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
    } t_out_item;

endpackage

// ===== hdl/usor_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module usor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/udp_socket_offload_registers_top.sv =====
// Top level: register file of a four-socket UDP offload controller.
//
// One transfer is accepted per cycle when the output side keeps up. Each
// accepted item updates the register state in the cycle it is accepted; a
// result appears on the output register in the next cycle. Buffer reads (bus
// reads of the receive buffer, transmit pulls) use the registered read port
// of the buffer RAM, which lines up with that output register stage. While
// the output register holds an untaken result, input is stalled; an item
// whose result is waiting does not block the next one otherwise.
module udp_socket_offload_registers_top #(
    parameter int SOCKET_COUNT = usor_pkg::SocketCount,
    parameter int BUFFER_BYTES = usor_pkg::BufferBytes
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  usor_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output usor_pkg::t_out_item o_data
);
    import usor_pkg::*;

    localparam int SW = $clog2(SOCKET_COUNT);
    localparam int BW = $clog2(BUFFER_BYTES);
    localparam int STORE = SOCKET_COUNT * BUFFER_BYTES;
    localparam int AW = $clog2(STORE);

    // Common registers
    logic [31:0] r_gateway, r_subnet, r_own_ip;
    logic [47:0] r_mac;
    // Per-socket registers
    logic [1:0]  r_mode    [SOCKET_COUNT];
    logic        r_open    [SOCKET_COUNT];
    logic [7:0]  r_irq     [SOCKET_COUNT];
    logic [15:0] r_sport   [SOCKET_COUNT];
    logic [31:0] r_dip     [SOCKET_COUNT];
    logic [15:0] r_dport   [SOCKET_COUNT];
    logic [15:0] r_txrd    [SOCKET_COUNT];
    logic [15:0] r_txwr    [SOCKET_COUNT];
    logic [15:0] r_rxsize  [SOCKET_COUNT];
    logic [15:0] r_rxrd    [SOCKET_COUNT];
    logic [15:0] r_rxmark  [SOCKET_COUNT];
    logic        r_pend    [SOCKET_COUNT];
    logic [11:0] r_fill;

    // Output stage: control part plus which field comes from the RAM
    logic        r_ovalid;
    t_out_item   r_out;
    logic        r_use_rx;   // read_data from rx RAM
    logic        r_use_tx;   // tx_byte from tx RAM

    logic accept;
    assign o_stall = r_ovalid && i_stall;
    assign accept  = i_valid && !o_stall;

    t_op        op;
    logic [15:0] a;
    logic [7:0]  wd;
    logic [SW-1:0] s, bs;
    logic [7:0]  r8;
    assign op = t_op'(i_data.operation);
    assign a  = i_data.address;
    assign wd = i_data.write_data;
    assign s  = i_data.net_socket[SW-1:0];
    assign bs = SW'(a[9:8]);
    assign r8 = a[7:0];

    logic is_com, is_sock, is_txbuf, is_rxbuf;
    assign is_com   = a < 16'h0030;
    assign is_sock  = a >= 16'h0400 && a < 16'h0800;
    assign is_txbuf = a >= 16'h4000 && a < 16'h6000;
    assign is_rxbuf = a >= 16'h6000 && a < 16'h8000;

    // Buffer RAMs
    logic          tx_we, tx_re, rx_we, rx_re;
    logic [AW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [7:0]    tx_rdata, rx_rdata;

    usor_ram #(.WIDTH(8), .DEPTH(STORE)) u_tx_ram (
        .i_clk(i_clk), .i_we(tx_we), .i_waddr(tx_waddr), .i_wdata(wd),
        .i_re(tx_re), .i_raddr(tx_raddr), .o_rdata(tx_rdata)
    );
    usor_ram #(.WIDTH(8), .DEPTH(STORE)) u_rx_ram (
        .i_clk(i_clk), .i_we(rx_we), .i_waddr(rx_waddr), .i_wdata(i_data.net_byte),
        .i_re(rx_re), .i_raddr(rx_raddr), .o_rdata(rx_rdata)
    );

    logic [BW-1:0] rx_off;
    logic          pull_take;
    logic [15:0]   txrd_inc;
    assign rx_off    = BW'(r_rxrd[s] + 16'(r_fill));
    assign pull_take = r_open[s] && r_pend[s] && (r_txrd[s] != r_txwr[s]);
    assign txrd_inc  = r_txrd[s] + 16'd1;

    assign tx_we    = accept && op == OP_BUS_WRITE && is_txbuf;
    assign tx_waddr = AW'(a - 16'h4000);
    assign tx_re    = accept && op == OP_TX_PULL && pull_take;
    assign tx_raddr = {s, r_txrd[s][BW-1:0]};
    assign rx_we    = accept && op == OP_RX_BYTE && r_open[s];
    assign rx_waddr = {s, rx_off};
    assign rx_re    = accept && op == OP_BUS_READ && is_rxbuf;
    assign rx_raddr = AW'(a - 16'h6000);

    // Bus read mux for register space
    logic [7:0]  rd_reg;
    logic [15:0] fsr;
    always_comb begin
        fsr    = FREE_SIZE_BASE - (r_txwr[bs] - r_txrd[bs]);
        rd_reg = BAD_READ;
        if (is_com) begin
            case (a[5:0]) inside
                6'h00: rd_reg = 8'h00;
                [6'h01:6'h04]: rd_reg = r_gateway[8*(4-int'(a[5:0]))+:8];
                [6'h05:6'h08]: rd_reg = r_subnet[8*(8-int'(a[5:0]))+:8];
                [6'h09:6'h0e]: rd_reg = r_mac[8*(14-int'(a[5:0]))+:8];
                [6'h0f:6'h12]: rd_reg = r_own_ip[8*(18-int'(a[5:0]))+:8];
                6'h16: rd_reg = IMR_VALUE;
                6'h1a, 6'h1b: rd_reg = MSIZE_VALUE;
                default: rd_reg = BAD_READ;
            endcase
        end else if (is_sock) begin
            case (r8)
                8'h00: rd_reg = {6'd0, r_mode[bs]};
                8'h02: rd_reg = r_irq[bs];
                8'h03: rd_reg = r_open[bs] ? STATUS_UDP : 8'h00;
                8'h04: rd_reg = r_sport[bs][15:8];
                8'h05: rd_reg = r_sport[bs][7:0];
                8'h20: rd_reg = fsr[15:8];
                8'h21: rd_reg = fsr[7:0];
                8'h22: rd_reg = r_txrd[bs][15:8];
                8'h23: rd_reg = r_txrd[bs][7:0];
                8'h24: rd_reg = r_txwr[bs][15:8];
                8'h25: rd_reg = r_txwr[bs][7:0];
                8'h26: rd_reg = r_rxsize[bs][15:8];
                8'h27: rd_reg = r_rxsize[bs][7:0];
                8'h28: rd_reg = r_rxrd[bs][15:8];
                8'h29: rd_reg = r_rxrd[bs][7:0];
                default: rd_reg = BAD_READ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (accept) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
        if (accept) begin
            r_out    <= '0;
            r_use_rx <= 1'b0;
            r_use_tx <= 1'b0;
            case (op)
                OP_BUS_READ: begin
                    r_out.read_data <= rd_reg;
                    r_use_rx        <= is_rxbuf;
                end
                OP_TX_PULL: begin
                    r_out.dest_ip   <= r_dip[s];
                    r_out.dest_port <= r_dport[s];
                    r_out.tx_valid  <= pull_take;
                    r_use_tx        <= pull_take;
                    r_out.tx_last   <= r_open[s] && r_pend[s]
                        && ((pull_take ? txrd_inc : r_txrd[s]) == r_txwr[s]);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_data = r_out;
        if (r_use_rx) o_data.read_data = rx_rdata;
        if (r_use_tx) o_data.tx_byte = tx_rdata;
    end
    assign o_valid = r_ovalid;

    // Register state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gateway <= '0; r_subnet <= '0; r_own_ip <= '0; r_mac <= '0;
            r_fill <= '0;
            for (int k = 0; k < SOCKET_COUNT; k++) begin
                r_mode[k] <= '0; r_open[k] <= 1'b0; r_irq[k] <= '0;
                r_sport[k] <= '0; r_dip[k] <= '0; r_dport[k] <= '0;
                r_txrd[k] <= '0; r_txwr[k] <= '0; r_rxsize[k] <= '0;
                r_rxrd[k] <= '0; r_rxmark[k] <= '0; r_pend[k] <= 1'b0;
            end
        end else if (accept) begin
            case (op)
                OP_BUS_WRITE: begin
                    if (is_com) begin
                        case (a[5:0]) inside
                            6'h00: begin
                                if (wd[7]) begin
                                    r_gateway <= '0; r_subnet <= '0;
                                    r_own_ip <= '0; r_mac <= '0;
                                    for (int k = 0; k < SOCKET_COUNT; k++) begin
                                        r_mode[k] <= '0; r_open[k] <= 1'b0;
                                        r_pend[k] <= 1'b0;
                                    end
                                end
                            end
                            [6'h01:6'h04]: r_gateway[8*(4-int'(a[5:0]))+:8] <= wd;
                            [6'h05:6'h08]: r_subnet[8*(8-int'(a[5:0]))+:8] <= wd;
                            [6'h09:6'h0e]: r_mac[8*(14-int'(a[5:0]))+:8] <= wd;
                            [6'h0f:6'h12]: r_own_ip[8*(18-int'(a[5:0]))+:8] <= wd;
                            default: ;
                        endcase
                    end else if (is_sock) begin
                        case (r8)
                            8'h00: r_mode[bs] <= (wd <= 8'd2) ? wd[1:0] : 2'd0;
                            8'h01: begin
                                if (r_mode[bs] == MODE_UDP) begin
                                    case (wd)
                                        CMD_OPEN: if (!r_open[bs]) begin
                                            r_open[bs] <= 1'b1; r_irq[bs] <= '0;
                                            r_sport[bs] <= '0; r_dip[bs] <= '0;
                                            r_dport[bs] <= '0; r_txrd[bs] <= '0;
                                            r_txwr[bs] <= '0; r_rxsize[bs] <= '0;
                                            r_rxrd[bs] <= '0; r_pend[bs] <= 1'b0;
                                        end
                                        CMD_CLOSE: if (r_open[bs]) begin
                                            r_open[bs] <= 1'b0; r_pend[bs] <= 1'b0;
                                        end
                                        CMD_SEND: if (r_open[bs]) r_pend[bs] <= 1'b1;
                                        CMD_RECV: if (r_open[bs]) begin
                                            r_rxsize[bs] <= r_rxsize[bs]
                                                - (r_rxrd[bs] - r_rxmark[bs]);
                                            if ((r_rxsize[bs] - (r_rxrd[bs] - r_rxmark[bs]))
                                                != 16'd0) begin
                                                r_irq[bs][2] <= 1'b1;
                                            end
                                        end
                                        default: ;
                                    endcase
                                end
                            end
                            8'h02: r_irq[bs] <= r_irq[bs] & ~wd;
                            8'h04: r_sport[bs][15:8] <= wd;
                            8'h05: r_sport[bs][7:0] <= wd;
                            8'h0c: r_dip[bs][31:24] <= wd;
                            8'h0d: r_dip[bs][23:16] <= wd;
                            8'h0e: r_dip[bs][15:8] <= wd;
                            8'h0f: r_dip[bs][7:0] <= wd;
                            8'h10: r_dport[bs][15:8] <= wd;
                            8'h11: r_dport[bs][7:0] <= wd;
                            8'h24: r_txwr[bs][15:8] <= wd;
                            8'h25: r_txwr[bs][7:0] <= wd;
                            8'h28: r_rxrd[bs][15:8] <= wd;
                            8'h29: r_rxrd[bs][7:0] <= wd;
                            default: ;
                        endcase
                    end
                end
                OP_RX_BYTE: begin
                    if (r_open[s]) begin
                        if (i_data.net_last) begin
                            r_rxsize[s] <= 16'(r_fill + ((r_fill != 12'hfff) ? 12'd1 : 12'd0));
                            r_rxmark[s] <= r_rxrd[s];
                            r_irq[s][2] <= 1'b1;
                            r_fill <= '0;
                        end else if (r_fill != 12'hfff) begin
                            r_fill <= r_fill + 12'd1;
                        end
                    end
                end
                OP_TX_PULL: begin
                    if (r_open[s] && r_pend[s]) begin
                        if (pull_take) r_txrd[s] <= txrd_inc;
                        if ((pull_take ? txrd_inc : r_txrd[s]) == r_txwr[s]) begin
                            r_pend[s] <= 1'b0;
                            r_irq[s][4] <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
